// ===== hdl/rlps_pkg.sv =====
`default_nettype none

package rlps_pkg;

  localparam int ColorW = 24;
  localparam int ShortW = 8;
  localparam int LongW  = 16;
  localparam int IndexW = 3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [IndexW-1:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [IndexW-1:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [IndexW-1:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [IndexW-1:0] REG_ONE_LOW   = 3'd3;
  localparam logic [IndexW-1:0] REG_LATCH     = 3'd4;

  localparam logic [ShortW-1:0] ZERO_HIGH_RST = 8'd8;
  localparam logic [ShortW-1:0] ZERO_LOW_RST  = 8'd25;
  localparam logic [ShortW-1:0] ONE_HIGH_RST  = 8'd22;
  localparam logic [ShortW-1:0] ONE_LOW_RST   = 8'd9;
  localparam logic [LongW-1:0]  LATCH_RST     = 16'd2000;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  // queue entry: classified beat
  typedef struct packed {
    logic              load;
    logic [ColorW-1:0] color;   // green, red, blue
  } cmd_t;

  // queue handshake toward the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // phase length for the current bit; zero acts as one tick
  function automatic logic [LongW-1:0] pick_len(input logic bit_val,
                                                input logic [ShortW-1:0] one_len,
                                                input logic [ShortW-1:0] zero_len);
    logic [ShortW-1:0] sel;
    sel = bit_val ? one_len : zero_len;
    return (sel == '0) ? LongW'(1) : LongW'(sel);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rlps_front.sv =====
`default_nettype none

module rlps_front
  import rlps_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          operation,
  input  wire logic [7:0]    red,
  input  wire logic [7:0]    green,
  input  wire logic [7:0]    blue,
  output q_head_t            head,
  input  wire logic          pop
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  assign cmd_in.load  = (operation == OP_LOAD);
  assign cmd_in.color = {green, red, blue};

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head.valid = (count != 2'd0);
  assign head.cmd   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== hdl/rlps_back.sv =====
`default_nettype none

module rlps_back
  import rlps_pkg::*;
#(
  parameter int BITS_PER_LED = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire q_head_t           head,
  output logic                   pop,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IndexW-1:0] cfg_index,
  input  wire logic [LongW-1:0]  cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   pin_level,
  output logic                   busy_res,
  output logic                   rejected
);

  localparam int WordW  = BITS_PER_LED;
  localparam int BitsW  = $clog2(BITS_PER_LED + 1);
  localparam int PadW   = BITS_PER_LED - ColorW;

  logic [ShortW-1:0] zero_high_ticks;
  logic [ShortW-1:0] zero_low_ticks;
  logic [ShortW-1:0] one_high_ticks;
  logic [ShortW-1:0] one_low_ticks;
  logic [LongW-1:0]  latch_ticks;

  phase_t            phase, phase_next;
  logic [WordW-1:0]  shift_word, shift_word_next;
  logic [BitsW-1:0]  bits_remaining, bits_remaining_next;
  logic [LongW-1:0]  phase_count, phase_count_next;

  logic [WordW-1:0]  load_word;
  logic [BitsW-1:0]  bits_dec;
  logic              expire;
  logic              res_pin, res_busy, res_rej;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high_ticks <= ZERO_HIGH_RST;
      zero_low_ticks  <= ZERO_LOW_RST;
      one_high_ticks  <= ONE_HIGH_RST;
      one_low_ticks   <= ONE_LOW_RST;
      latch_ticks     <= LATCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ZERO_HIGH: zero_high_ticks <= cfg_data[ShortW-1:0];
        REG_ZERO_LOW:  zero_low_ticks  <= cfg_data[ShortW-1:0];
        REG_ONE_HIGH:  one_high_ticks  <= cfg_data[ShortW-1:0];
        REG_ONE_LOW:   one_low_ticks   <= cfg_data[ShortW-1:0];
        REG_LATCH:     latch_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pop       = head.valid && (!out_valid || out_ready);
  assign load_word = WordW'(head.cmd.color) << PadW;
  assign expire    = (phase_count <= LongW'(1));
  assign bits_dec  = (bits_remaining == '0) ? '0 : bits_remaining - BitsW'(1);

  // next state
  always_comb begin
    phase_next          = phase;
    shift_word_next     = shift_word;
    bits_remaining_next = bits_remaining;
    phase_count_next    = phase_count;
    if (pop) begin
      if (head.cmd.load) begin
        if (phase == PH_IDLE) begin
          shift_word_next     = load_word;
          bits_remaining_next = BitsW'(BITS_PER_LED);
          phase_next          = PH_HIGH;
          phase_count_next    = pick_len(load_word[WordW-1], one_high_ticks,
                                         zero_high_ticks);
        end
      end else begin
        unique case (phase)
          PH_IDLE: ;
          PH_HIGH: begin
            if (expire) begin
              phase_next       = PH_LOW;
              phase_count_next = pick_len(shift_word[WordW-1], one_low_ticks,
                                          zero_low_ticks);
            end else begin
              phase_count_next = phase_count - LongW'(1);
            end
          end
          PH_LOW: begin
            if (expire) begin
              shift_word_next     = shift_word << 1;
              bits_remaining_next = bits_dec;
              if (bits_dec != '0) begin
                phase_next       = PH_HIGH;
                phase_count_next = pick_len(shift_word[WordW-2], one_high_ticks,
                                            zero_high_ticks);
              end else begin
                phase_next       = PH_LATCH;
                phase_count_next = (latch_ticks == '0) ? LongW'(1) : latch_ticks;
              end
            end else begin
              phase_count_next = phase_count - LongW'(1);
            end
          end
          PH_LATCH: begin
            if (expire) begin
              phase_next       = PH_IDLE;
              phase_count_next = '0;
            end else begin
              phase_count_next = phase_count - LongW'(1);
            end
          end
        endcase
      end
    end
  end

  // result of the popped beat, from the state before it
  always_comb begin
    res_pin  = (phase == PH_HIGH);
    res_busy = (phase != PH_IDLE) || head.cmd.load;
    res_rej  = head.cmd.load && (phase != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      shift_word     <= '0;
      bits_remaining <= '0;
      phase_count    <= '0;
      out_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      shift_word     <= shift_word_next;
      bits_remaining <= bits_remaining_next;
      phase_count    <= phase_count_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pin_level <= res_pin;
      busy_res  <= res_busy;
      rejected  <= res_rej;
    end
  end

  a_bits_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HIGH || phase == PH_LOW) |-> (bits_remaining != '0))
    else $error("bit phase with no bits left");
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (phase_count != '0))
    else $error("active phase with zero count");
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rejected) |-> busy_res)
    else $error("reject reported while idle");
  a_pin_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pin_level) |-> (busy_res && !rejected || busy_res))
    else $error("pin high while idle");
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE && !(pop && head.cmd.load)) |=> (phase == PH_IDLE))
    else $error("left idle without a load");

endmodule

`default_nettype wire

// ===== hdl/rgb_led_pulse_serializer_core.sv =====
`default_nettype none

// Channel   Signals                                  Dir  Beat
// in        in_valid/in_ready, operation,rgb         in   tick or color load
// out       out_valid/out_ready, pin_level,busy_res, out  one result per in beat
//           rejected
// cfg       cfg_valid/cfg_ready, cfg_index,cfg_data  in   register write
//
// One in beat per cycle while out_ready is high; each result is registered.
// A 2-entry queue between front and back holds beats while the output stalls.
// Reset loads the default timing registers and leaves the serializer idle.
// cfg_ready is always high; writes take effect on the next cycle.

module rgb_led_pulse_serializer_core
  import rlps_pkg::*;
#(
  parameter int BITS_PER_LED = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              operation,
  input  wire logic [7:0]        red,
  input  wire logic [7:0]        green,
  input  wire logic [7:0]        blue,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   pin_level,
  output logic                   busy_res,
  output logic                   rejected,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IndexW-1:0] cfg_index,
  input  wire logic [LongW-1:0]  cfg_data
);

  q_head_t head;
  logic    pop;

  rlps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .head      (head),
    .pop       (pop)
  );

  rlps_back #(
    .BITS_PER_LED (BITS_PER_LED)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pin_level (pin_level),
    .busy_res  (busy_res),
    .rejected  (rejected)
  );

endmodule

`default_nettype wire

// ===== dv/tb_rgb_led_pulse_serializer_core.sv =====
`timescale 1ns / 100ps

module tb_rgb_led_pulse_serializer_core;
  import rlps_pkg::*;

  localparam int QUIET_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PHASES    = 8;
  localparam int BEATS_PER_PHASE = 90;

  localparam logic [IndexW-1:0] REG_SPARE = REG_LATCH + 3'd1;

  typedef struct packed {
    logic pin;
    logic busy;
    logic rej;
  } line_sample_t;

  typedef enum logic [1:0] {
    ROW_BEAT,
    ROW_REG,
    ROW_DRAIN
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              op;
    logic [ColorW-1:0] rgb;     // green, red, blue
    logic [IndexW-1:0] idx;
    logic [LongW-1:0]  data;
    logic              chk;
    line_sample_t      exp;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              operation;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic              out_valid;
  logic              out_ready;
  logic              pin_level;
  logic              busy_res;
  logic              rejected;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IndexW-1:0] cfg_index;
  logic [LongW-1:0]  cfg_data;

  rgb_led_pulse_serializer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pin_level (pin_level),
    .busy_res  (busy_res),
    .rejected  (rejected),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // timing registers and serializer state as the line sees them
  logic [ShortW-1:0] t_zero_high;
  logic [ShortW-1:0] t_zero_low;
  logic [ShortW-1:0] t_one_high;
  logic [ShortW-1:0] t_one_low;
  logic [LongW-1:0]  t_latch;
  logic [ColorW-1:0] line_word;
  logic [4:0]        line_bits;
  phase_t            line_phase;
  logic [LongW-1:0]  line_count;

  line_sample_t pin_exp_q[$];
  plan_row_t    plan[$];
  int           err_count;
  int           quiet_cycles;
  int           idle_pct;
  int           stall_pct;
  int           idle_by_mode[4]  = '{0, 55, 0, 33};
  int           stall_by_mode[4] = '{0, 0, 55, 33};

  function automatic logic [LongW-1:0] phase_ticks(input logic high_side);
    logic [ShortW-1:0] sel;
    if (line_word[ColorW-1]) begin
      sel = high_side ? t_one_high : t_one_low;
    end else begin
      sel = high_side ? t_zero_high : t_zero_low;
    end
    return (sel == '0) ? LongW'(1) : LongW'(sel);
  endfunction

  function automatic line_sample_t advance_line(input logic op, input logic [ColorW-1:0] rgb);
    line_sample_t s;
    s.pin  = (line_phase == PH_HIGH);
    s.busy = (line_phase != PH_IDLE);
    s.rej  = 1'b0;
    if (op == OP_LOAD) begin
      if (s.busy) begin
        s.rej = 1'b1;
      end else begin
        line_word  = rgb;
        line_bits  = 5'(ColorW);
        line_phase = PH_HIGH;
        line_count = phase_ticks(1'b1);
        s.pin      = 1'b0;
        s.busy     = 1'b1;
      end
    end else if (line_phase != PH_IDLE) begin
      if (line_count != '0) line_count = line_count - 1'b1;
      if (line_count == '0) begin
        case (line_phase)
          PH_HIGH: begin
            line_phase = PH_LOW;
            line_count = phase_ticks(1'b0);
          end
          PH_LOW: begin
            line_word = line_word << 1;
            if (line_bits != '0) line_bits = line_bits - 1'b1;
            if (line_bits != '0) begin
              line_phase = PH_HIGH;
              line_count = phase_ticks(1'b1);
            end else begin
              line_phase = PH_LATCH;
              line_count = (t_latch == '0) ? LongW'(1) : t_latch;
            end
          end
          default: begin
            line_phase = PH_IDLE;
            line_count = '0;
          end
        endcase
      end
    end
    return s;
  endfunction

  function automatic plan_row_t beat(input logic op, input logic [ColorW-1:0] rgb);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_BEAT;
    r.op   = op;
    r.rgb  = rgb;
    return r;
  endfunction

  function automatic plan_row_t beat_chk(input logic op, input logic [ColorW-1:0] rgb,
                                         input logic pin, input logic busy, input logic rej);
    plan_row_t r;
    r     = beat(op, rgb);
    r.chk = 1'b1;
    r.exp = '{pin: pin, busy: busy, rej: rej};
    return r;
  endfunction

  function automatic plan_row_t reg_wr(input logic [IndexW-1:0] idx,
                                       input logic [LongW-1:0] data);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t drain();
    plan_row_t r;
    r      = '0;
    r.kind = ROW_DRAIN;
    return r;
  endfunction

  // short lengths mostly, upper byte is junk the register must drop
  function automatic logic [LongW-1:0] rand_len();
    logic [ShortW-1:0] len;
    len = ($urandom_range(7) == 0) ? ShortW'($urandom_range(255)) : ShortW'($urandom_range(4));
    return {ShortW'($urandom_range(255)), len};
  endfunction

  task automatic note_fail(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  task automatic push_beat(input logic op, input logic [ColorW-1:0] rgb,
                           input logic chk, input line_sample_t exp);
    line_sample_t s;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    green     <= rgb[23:16];
    red       <= rgb[15:8];
    blue      <= rgb[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    s = advance_line(op, rgb);
    pin_exp_q.push_back(chk ? exp : s);
  endtask

  task automatic drain_line();
    while (line_phase != PH_IDLE) push_beat(OP_TICK, ColorW'($urandom), 1'b0, '0);
  endtask

  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [LongW-1:0] data);
    in_valid <= 1'b0;
    while (pin_exp_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ZERO_HIGH: t_zero_high = data[ShortW-1:0];
      REG_ZERO_LOW:  t_zero_low  = data[ShortW-1:0];
      REG_ONE_HIGH:  t_one_high  = data[ShortW-1:0];
      REG_ONE_LOW:   t_one_low   = data[ShortW-1:0];
      REG_LATCH:     t_latch     = data;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    line_sample_t want;
    line_sample_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{pin: pin_level, busy: busy_res, rej: rejected};
      if (pin_exp_q.size() == 0) begin
        note_fail($sformatf("unexpected result beat: pin %0b busy %0b rej %0b",
                            got.pin, got.busy, got.rej));
      end else begin
        want = pin_exp_q.pop_front();
        if (got !== want) begin
          note_fail($sformatf("mismatch: pin %0b/%0b busy %0b/%0b rej %0b/%0b (exp/got)",
                              want.pin, got.pin, want.busy, got.busy, want.rej, got.rej));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rgb_led_pulse_serializer_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t row;
    logic      op;
    int        mode;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    operation    <= OP_TICK;
    red          <= '0;
    green        <= '0;
    blue         <= '0;
    out_ready    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_ZERO_HIGH;
    cfg_data     <= '0;
    quiet_cycles = 0;
    err_count    = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    t_zero_high  = ZERO_HIGH_RST;
    t_zero_low   = ZERO_LOW_RST;
    t_one_high   = ONE_HIGH_RST;
    t_one_low    = ONE_LOW_RST;
    t_latch      = LATCH_RST;
    line_word    = '0;
    line_bits    = '0;
    line_phase   = PH_IDLE;
    line_count   = '0;

    plan = '{
      // default timing out of reset
      beat_chk(OP_TICK, 24'h000000, 1'b0, 1'b0, 1'b0),
      beat_chk(OP_LOAD, 24'hFF0001, 1'b0, 1'b1, 1'b0),
      beat_chk(OP_LOAD, 24'h123456, 1'b1, 1'b1, 1'b1),
      beat_chk(OP_TICK, 24'hFFFFFF, 1'b1, 1'b1, 1'b0),
      // zero lengths act as one tick; upper data bits dropped
      reg_wr(REG_ZERO_HIGH, 16'hFF00),
      reg_wr(REG_ZERO_LOW,  16'h0000),
      reg_wr(REG_ONE_HIGH,  16'hAB00),
      reg_wr(REG_ONE_LOW,   16'h0100),
      reg_wr(REG_LATCH,     16'h0000),
      drain(),
      beat_chk(OP_TICK, 24'h000000, 1'b0, 1'b0, 1'b0),
      beat(OP_LOAD, 24'h000000),
      beat(OP_TICK, 24'h000000),
      drain(),
      beat(OP_LOAD, 24'hFFFFFF),
      beat_chk(OP_LOAD, 24'h000000, 1'b1, 1'b1, 1'b1),
      drain(),
      // longest lengths; first high phase runs its full count
      reg_wr(REG_ZERO_HIGH, 16'hFFFF),
      reg_wr(REG_ZERO_LOW,  16'h00FF),
      reg_wr(REG_ONE_HIGH,  16'h00FF),
      reg_wr(REG_ONE_LOW,   16'h7FFF),
      reg_wr(REG_LATCH,     16'hFFFF),
      reg_wr(REG_SPARE,     16'h1234),
      beat(OP_LOAD, 24'h800001),
      beat(OP_TICK, 24'h000000),
      // short nonzero lengths
      reg_wr(REG_ZERO_HIGH, 16'h0001),
      reg_wr(REG_ZERO_LOW,  16'h0002),
      reg_wr(REG_ONE_HIGH,  16'h0003),
      reg_wr(REG_ONE_LOW,   16'h0001),
      reg_wr(REG_LATCH,     16'h0001),
      drain(),
      beat(OP_LOAD, 24'hA55AC3),
      beat_chk(OP_LOAD, 24'hFFFFFF, 1'b1, 1'b1, 1'b1),
      drain(),
      beat_chk(OP_TICK, 24'hFFFFFF, 1'b0, 1'b0, 1'b0),
      beat_chk(OP_LOAD, 24'h0F0F0F, 1'b0, 1'b1, 1'b0),
      drain()
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      case (row.kind)
        ROW_BEAT: push_beat(row.op, row.rgb, row.chk, row.exp);
        ROW_REG:  write_reg(row.idx, row.data);
        default:  drain_line();
      endcase
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode      = ph % 4;
      idle_pct  = idle_by_mode[mode];
      stall_pct = stall_by_mode[mode];
      // a frame left running picks up the new lengths
      write_reg(REG_ZERO_HIGH, rand_len());
      write_reg(REG_ZERO_LOW,  rand_len());
      write_reg(REG_ONE_HIGH,  rand_len());
      write_reg(REG_ONE_LOW,   rand_len());
      write_reg(REG_LATCH, ($urandom_range(7) == 0) ? LongW'($urandom_range(300))
                                                   : LongW'($urandom_range(12)));
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        // mostly whole frames; a few loads land while busy
        if (line_phase == PH_IDLE) begin
          op = ($urandom_range(9) < 8) ? OP_LOAD : OP_TICK;
        end else begin
          op = ($urandom_range(19) == 0) ? OP_LOAD : OP_TICK;
        end
        push_beat(op, ColorW'($urandom), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pin_exp_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES * 2) @(posedge clk);
    if (err_count == 0) begin
      $display("rgb_led_pulse_serializer_core regression: pass");
    end else begin
      $display("rgb_led_pulse_serializer_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rlps_pkg.sv
hdl/rlps_front.sv
hdl/rlps_back.sv
hdl/rgb_led_pulse_serializer_core.sv
dv/tb_rgb_led_pulse_serializer_core.sv
